// ===== design/lfla_pkg.sv =====
// ----------------------------------------------------------------------------
// lfla_pkg
// Shared types and constants of the lazy free list allocator: request and
// response records, request and error codes, controller states and the
// configuration register map.
// ----------------------------------------------------------------------------
package lfla_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int IDX_W      = $clog2(POOL_DEPTH);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [IDX_W-1:0] FIRST_NODE = IDX_W'(1);
    localparam logic [IDX_W-1:0] CAP_MAX    = IDX_W'(POOL_DEPTH - 2);
    localparam logic [IDX_W-1:0] CAP_RESET  = IDX_W'(1022);

    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_EXHAUSTED = 2'd1,
        ERR_EMPTY     = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC
    } state_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] free_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] alloc_index;
        logic [1:0]       error;
        logic [IDX_W-1:0] in_use;
        logic [IDX_W-1:0] peak;
    } rsp_t;

endpackage

// ===== design/lfla_ram.sv =====
// ----------------------------------------------------------------------------
// lfla_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module lfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lfla_cfg.sv =====
// ----------------------------------------------------------------------------
// lfla_cfg
// APB register file of the allocator. Holds the capacity register and derives
// the capacity in effect, which never exceeds the nodes the pool can supply.
// ----------------------------------------------------------------------------
module lfla_cfg
    import lfla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [IDX_W-1:0]      cap_eff
);

    logic [IDX_W-1:0]        capacity_reg;
    logic [IDX_W-1:0]        capacity_next;
    logic [APB_ADDR_W-3:0]   reg_index;
    logic                    wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        prdata        = '0;
        unique case (reg_index)
            REG_CAPACITY:
            begin
                prdata = APB_DATA_W'(capacity_reg);
                if (wr_en)
                begin
                    capacity_next = pwdata[IDX_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign cap_eff = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;

endmodule

// ===== design/lazy_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// lazy_free_list_allocator_top
// Node allocator over a fixed pool with a lazily initialized linked free list.
//
// Every request returns exactly one response. An allocate that succeeds takes
// two cycles, because the link of the current head must be read from the
// one-cycle link memory before the new head is known. Free, clear, no-op and
// a failing allocate take one cycle. After reset the block spends one cycle
// writing the first link before it takes requests. Node 0 is never handed out.
// ----------------------------------------------------------------------------
module lazy_free_list_allocator_top
    import lfla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] used_reg;
    logic [IDX_W-1:0] used_next;
    logic [IDX_W-1:0] peak_reg;
    logic [IDX_W-1:0] peak_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_load;

    logic [IDX_W-1:0] cap_eff;
    logic             accept;
    logic [IDX_W-1:0] given;
    err_code_t        err;
    logic [IDX_W:0]   succ_wide;
    logic [IDX_W-1:0] succ;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_rdata;

    lfla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cap_eff (cap_eff)
    );

    lfla_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign succ_wide = {1'b0, head_reg} + (IDX_W+1)'(1);
    assign succ      = (succ_wide >= (IDX_W+1)'(POOL_DEPTH)) ? FIRST_NODE
                                                             : succ_wide[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        used_next  = used_reg;
        peak_next  = peak_reg;
        ram_we     = 1'b0;
        ram_waddr  = FIRST_NODE;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        rsp_load   = 1'b0;
        given      = '0;
        err        = ERR_OK;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_load = 1'b1;
                    unique case (req.req_type)
                        REQ_ALLOC:
                        begin
                            if (used_reg >= cap_eff)
                            begin
                                err = ERR_EXHAUSTED;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rsp_load   = 1'b0;
                                state_next = ST_ALLOC;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (used_reg == '0)
                            begin
                                err = ERR_EMPTY;
                            end
                            else if ((req.free_index != '0) &&
                                     ({1'b0, req.free_index} < (IDX_W+1)'(POOL_DEPTH)))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = req.free_index;
                                ram_wdata = head_reg;
                                head_next = req.free_index;
                                used_next = used_reg - IDX_W'(1);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            ram_we    = 1'b1;
                            head_next = FIRST_NODE;
                            used_next = '0;
                            peak_next = '0;
                        end
                        default:
                        begin
                            err = ERR_OK;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if (ram_rdata == '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = succ;
                    head_next = succ;
                end
                else
                begin
                    head_next = ram_rdata;
                end
                used_next  = used_reg + IDX_W'(1);
                peak_next  = (used_next > peak_reg) ? used_next : peak_reg;
                given      = head_reg;
                rsp_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.alloc_index = given;
        rsp_next.error       = err;
        rsp_next.in_use      = used_next;
        rsp_next.peak        = peak_next;
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            head_reg      <= FIRST_NODE;
            used_reg      <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_alloc_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |-> !rsp_valid_reg)
        else $error("Allocate in flight while a response is still held.");

    a_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg != '0)
        else $error("Free list head points at node zero.");

    a_peak_covers_use: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_reg >= used_reg) && (used_reg <= CAP_MAX))
        else $error("In-use count exceeds the peak or the pool.");

    a_alloc_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |=> (state_reg == ST_IDLE) && rsp_valid_reg)
        else $error("Allocate did not complete in the following cycle.");
`endif

endmodule
